// ===== src/rlmps_pkg.sv =====
// Shared types and constants for the RGB LED matrix scan engine.
package rlmps_pkg;

  localparam int DEF_MATRIX_ROWS    = 8;
  localparam int DEF_MATRIX_COLUMNS = 8;
  localparam int DEF_GRAY_LEVELS    = 16;

  localparam int CMD_W    = 2;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int CHAN_W   = 8;
  localparam int LEVEL_W  = 4;
  localparam int MASK_W   = 8;
  localparam int NUM_COLORS = 3;

  localparam int COLOR_RED   = 0;
  localparam int COLOR_GREEN = 1;
  localparam int COLOR_BLUE  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SCAN  = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } req_t;

endpackage

// ===== src/rlmps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rlmps_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rgb_led_matrix_pwm_scanner.sv =====
// Frame buffer and row scan engine for a multiplexed RGB LED matrix.
//
//   channel | direction | handshake               | payload
//   input   | in        | in_valid_i / in_ready_o  | cmd, row, column, red/green/blue_in
//   output  | out       | out_valid_o / out_ready_i| scan_row/level, color bits, color out
//
// Each item first reads its row word from the frame RAM, then compares or
// merges and writes the row back. The RAM port pair sets this.
// Reset clears the line and level counters and the per-row valid flags; a row
// never written reads as all zero intensities, so no clearing pass is needed.
// A result not yet taken stalls only the item after it, in its compare or write step.
module rgb_led_matrix_pwm_scanner #(
  parameter int MATRIX_ROWS    = rlmps_pkg::DEF_MATRIX_ROWS,
  parameter int MATRIX_COLUMNS = rlmps_pkg::DEF_MATRIX_COLUMNS,
  parameter int GRAY_LEVELS    = rlmps_pkg::DEF_GRAY_LEVELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rlmps_pkg::CMD_W-1:0]  cmd_i,
  input  logic [rlmps_pkg::ROW_W-1:0]  row_i,
  input  logic [rlmps_pkg::COL_W-1:0]  column_i,
  input  logic [rlmps_pkg::CHAN_W-1:0] red_in_i,
  input  logic [rlmps_pkg::CHAN_W-1:0] green_in_i,
  input  logic [rlmps_pkg::CHAN_W-1:0] blue_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rlmps_pkg::ROW_W-1:0]  scan_row_o,
  output logic [rlmps_pkg::LEVEL_W-1:0] scan_level_o,
  output logic [rlmps_pkg::MASK_W-1:0] green_bits_o,
  output logic [rlmps_pkg::MASK_W-1:0] red_bits_o,
  output logic [rlmps_pkg::MASK_W-1:0] blue_bits_o,
  output logic [rlmps_pkg::CHAN_W-1:0] red_out_o,
  output logic [rlmps_pkg::CHAN_W-1:0] green_out_o,
  output logic [rlmps_pkg::CHAN_W-1:0] blue_out_o
);

  import rlmps_pkg::*;

  localparam int LineW    = $clog2(MATRIX_ROWS);
  localparam int ColAW    = $clog2(MATRIX_COLUMNS);
  localparam int LvlW     = $clog2(GRAY_LEVELS);
  localparam int WordW    = NUM_COLORS * MATRIX_COLUMNS * CHAN_W;
  localparam int VisCols  = (MATRIX_COLUMNS < MASK_W) ? MATRIX_COLUMNS : MASK_W;

  state_e state_q, state_d;
  req_t   req_q;
  logic [LineW-1:0] addr_q, raddr;
  logic [LineW-1:0] line_q, line_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic [MATRIX_ROWS-1:0] row_valid_q, row_valid_d;

  logic in_fire, exec_fire, ram_re, ram_we, pixel_ok;
  logic [WordW-1:0] rdata, row_word, merged;
  logic [ColAW-1:0] col_idx;

  logic [CHAN_W-1:0] pix_sel [NUM_COLORS];
  logic [MASK_W-1:0] cmp_bits [NUM_COLORS];

  logic                out_valid_q, out_valid_d;
  logic [ROW_W-1:0]    scan_row_q, scan_row_d;
  logic [LEVEL_W-1:0]  scan_level_q, scan_level_d;
  logic [MASK_W-1:0]   green_bits_q, green_bits_d;
  logic [MASK_W-1:0]   red_bits_q, red_bits_d;
  logic [MASK_W-1:0]   blue_bits_q, blue_bits_d;
  logic [CHAN_W-1:0]   red_out_q, red_out_d;
  logic [CHAN_W-1:0]   green_out_q, green_out_d;
  logic [CHAN_W-1:0]   blue_out_q, blue_out_d;

  rlmps_ram #(
    .Width (WordW),
    .Depth (MATRIX_ROWS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (merged),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    exec_fire  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: exec_fire  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;
  assign ram_re  = in_fire;
  assign raddr   = (cmd_e'(cmd_i) == CMD_SCAN) ? line_q : LineW'(32'(row_i));

  assign pixel_ok = (32'(req_q.row) < MATRIX_ROWS) && (32'(req_q.column) < MATRIX_COLUMNS);
  assign col_idx  = ColAW'(32'(req_q.column));

  // Rows never written read as zero
  assign row_word = row_valid_q[addr_q] ? rdata : '0;

  always_comb begin
    logic [CHAN_W-1:0] wr_val [NUM_COLORS];
    wr_val[COLOR_RED]   = (req_q.cmd == CMD_SET) ? req_q.red   : '0;
    wr_val[COLOR_GREEN] = (req_q.cmd == CMD_SET) ? req_q.green : '0;
    wr_val[COLOR_BLUE]  = (req_q.cmd == CMD_SET) ? req_q.blue  : '0;
    merged = row_word;
    for (int c = 0; c < NUM_COLORS; c++) begin
      pix_sel[c]  = '0;
      cmp_bits[c] = '0;
      for (int k = 0; k < MATRIX_COLUMNS; k++) begin
        if (ColAW'(k) == col_idx) begin
          pix_sel[c] = row_word[(c*MATRIX_COLUMNS+k)*CHAN_W +: CHAN_W];
          merged[(c*MATRIX_COLUMNS+k)*CHAN_W +: CHAN_W] = wr_val[c];
        end
      end
      for (int k = 0; k < VisCols; k++) begin
        cmp_bits[c][k] = row_word[(c*MATRIX_COLUMNS+k)*CHAN_W +: CHAN_W] > CHAN_W'(level_q);
      end
    end
  end

  assign ram_we = exec_fire && pixel_ok &&
                  (req_q.cmd == CMD_SET || req_q.cmd == CMD_CLEAR);

  always_comb begin
    row_valid_d = row_valid_q;
    if (ram_we) begin
      row_valid_d[addr_q] = 1'b1;
    end
  end

  // Advance line, and level after the last line
  always_comb begin
    line_d  = line_q;
    level_d = level_q;
    if (exec_fire && req_q.cmd == CMD_SCAN) begin
      if (line_q == LineW'(MATRIX_ROWS - 1)) begin
        line_d  = '0;
        level_d = (level_q == LvlW'(GRAY_LEVELS - 1)) ? '0 : level_q + 1'b1;
      end else begin
        line_d = line_q + 1'b1;
      end
    end
  end

  always_comb begin
    scan_row_d   = scan_row_q;
    scan_level_d = scan_level_q;
    green_bits_d = green_bits_q;
    red_bits_d   = red_bits_q;
    blue_bits_d  = blue_bits_q;
    red_out_d    = red_out_q;
    green_out_d  = green_out_q;
    blue_out_d   = blue_out_q;
    out_valid_d  = out_valid_q;
    if (exec_fire) begin
      out_valid_d  = 1'b1;
      scan_row_d   = '0;
      scan_level_d = '0;
      green_bits_d = '0;
      red_bits_d   = '0;
      blue_bits_d  = '0;
      red_out_d    = '0;
      green_out_d  = '0;
      blue_out_d   = '0;
      if (req_q.cmd == CMD_SCAN) begin
        scan_row_d   = ROW_W'(32'(line_q));
        scan_level_d = LEVEL_W'(32'(level_q));
        green_bits_d = cmp_bits[COLOR_GREEN];
        red_bits_d   = cmp_bits[COLOR_RED];
        blue_bits_d  = cmp_bits[COLOR_BLUE];
      end else if (req_q.cmd == CMD_READ && pixel_ok) begin
        red_out_d   = pix_sel[COLOR_RED];
        green_out_d = pix_sel[COLOR_GREEN];
        blue_out_d  = pix_sel[COLOR_BLUE];
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_q      <= '0;
      level_q     <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      level_q     <= level_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.cmd    <= cmd_e'(cmd_i);
      req_q.row    <= row_i;
      req_q.column <= column_i;
      req_q.red    <= red_in_i;
      req_q.green  <= green_in_i;
      req_q.blue   <= blue_in_i;
      addr_q       <= raddr;
    end
    scan_row_q   <= scan_row_d;
    scan_level_q <= scan_level_d;
    green_bits_q <= green_bits_d;
    red_bits_q   <= red_bits_d;
    blue_bits_q  <= blue_bits_d;
    red_out_q    <= red_out_d;
    green_out_q  <= green_out_d;
    blue_out_q   <= blue_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign scan_row_o   = scan_row_q;
  assign scan_level_o = scan_level_q;
  assign green_bits_o = green_bits_q;
  assign red_bits_o   = red_bits_q;
  assign blue_bits_o  = blue_bits_q;
  assign red_out_o    = red_out_q;
  assign green_out_o  = green_out_q;
  assign blue_out_o   = blue_out_q;

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(line_q) < MATRIX_ROWS)
    else $error("scan line out of range");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(level_q) < GRAY_LEVELS)
    else $error("gray level out of range");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && req_q.cmd == CMD_SCAN && line_q != LineW'(MATRIX_ROWS - 1))
    |=> $stable(level_q))
    else $error("gray level moved before the last line");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_EXEC && !in_ready_o))
    else $error("frame write outside the execute cycle");

endmodule

// ===== test/rgb_led_matrix_pwm_scanner_check.sv =====
// Checker for the LED matrix scan engine: tracks the frame, predicts and compares results.
module rgb_led_matrix_pwm_scanner_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [rlmps_pkg::CMD_W-1:0]    cmd_i,
  input  logic [rlmps_pkg::ROW_W-1:0]    row_i,
  input  logic [rlmps_pkg::COL_W-1:0]    column_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   red_in_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   green_in_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   blue_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [rlmps_pkg::ROW_W-1:0]    scan_row_i,
  input  logic [rlmps_pkg::LEVEL_W-1:0]  scan_level_i,
  input  logic [rlmps_pkg::MASK_W-1:0]   green_bits_i,
  input  logic [rlmps_pkg::MASK_W-1:0]   red_bits_i,
  input  logic [rlmps_pkg::MASK_W-1:0]   blue_bits_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   red_out_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   green_out_i,
  input  logic [rlmps_pkg::CHAN_W-1:0]   blue_out_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  import rlmps_pkg::*;

  localparam int ROWS   = DEF_MATRIX_ROWS;
  localparam int COLS   = DEF_MATRIX_COLUMNS;
  localparam int LEVELS = DEF_GRAY_LEVELS;

  typedef struct packed {
    logic [ROW_W-1:0]   scan_row;
    logic [LEVEL_W-1:0] scan_level;
    logic [MASK_W-1:0]  green_bits;
    logic [MASK_W-1:0]  red_bits;
    logic [MASK_W-1:0]  blue_bits;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
  } pixel_result_t;

  logic [CHAN_W-1:0]  frame_q [ROWS][NUM_COLORS][COLS];
  logic [ROW_W-1:0]   line_q;
  logic [LEVEL_W-1:0] level_q;
  pixel_result_t      result_fifo [$];
  pixel_result_t      want;
  pixel_result_t      got;

  function automatic logic [MASK_W-1:0] lit_columns(int line, int color, int level);
    logic [MASK_W-1:0] mask;
    mask = '0;
    for (int c = 0; c < COLS && c < MASK_W; c++) begin
      if (int'(frame_q[line][color][c]) > level) mask[c] = 1'b1;
    end
    return mask;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val !== act_val) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Work out the result of one accepted item and update the frame and counters.
  task automatic predict_item();
    pixel_result_t res;
    bit in_frame;
    res = '0;
    in_frame = (int'(row_i) < ROWS) && (int'(column_i) < COLS);
    case (cmd_e'(cmd_i))
      CMD_SET: begin
        if (in_frame) begin
          frame_q[row_i][COLOR_RED][column_i]   = red_in_i;
          frame_q[row_i][COLOR_GREEN][column_i] = green_in_i;
          frame_q[row_i][COLOR_BLUE][column_i]  = blue_in_i;
        end
      end
      CMD_CLEAR: begin
        if (in_frame) begin
          for (int k = 0; k < NUM_COLORS; k++) frame_q[row_i][k][column_i] = '0;
        end
      end
      CMD_READ: begin
        if (in_frame) begin
          res.red_out   = frame_q[row_i][COLOR_RED][column_i];
          res.green_out = frame_q[row_i][COLOR_GREEN][column_i];
          res.blue_out  = frame_q[row_i][COLOR_BLUE][column_i];
        end
      end
      default: begin
        res.scan_row   = line_q;
        res.scan_level = level_q;
        res.green_bits = lit_columns(int'(line_q), COLOR_GREEN, int'(level_q));
        res.red_bits   = lit_columns(int'(line_q), COLOR_RED, int'(level_q));
        res.blue_bits  = lit_columns(int'(line_q), COLOR_BLUE, int'(level_q));
        // advance the line; step the level once per full frame
        if (int'(line_q) == ROWS - 1) begin
          line_q  = '0;
          level_q = (int'(level_q) == LEVELS - 1) ? '0 : level_q + 1'b1;
        end else begin
          line_q = line_q + 1'b1;
        end
      end
    endcase
    result_fifo.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++)
        for (int k = 0; k < NUM_COLORS; k++)
          for (int c = 0; c < COLS; c++) frame_q[r][k][c] = '0;
      line_q  = '0;
      level_q = '0;
      result_fifo.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_item();
      if (out_valid_i && out_ready_i) begin
        got = {scan_row_i, scan_level_i, green_bits_i, red_bits_i, blue_bits_i,
               red_out_i, green_out_i, blue_out_i};
        if (result_fifo.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none expected, expected nothing, got %h", $time, got);
        end else begin
          want = result_fifo.pop_front();
          check_field("scan_row", int'(want.scan_row), int'(got.scan_row));
          check_field("scan_level", int'(want.scan_level), int'(got.scan_level));
          check_field("green_bits", int'(want.green_bits), int'(got.green_bits));
          check_field("red_bits", int'(want.red_bits), int'(got.red_bits));
          check_field("blue_bits", int'(want.blue_bits), int'(got.blue_bits));
          check_field("red_out", int'(want.red_out), int'(got.red_out));
          check_field("green_out", int'(want.green_out), int'(got.green_out));
          check_field("blue_out", int'(want.blue_out), int'(got.blue_out));
          checked_o++;
        end
      end
      pending_o = result_fifo.size();
    end
  end

endmodule

// ===== test/rgb_led_matrix_pwm_scanner_test.sv =====
// Testbench top for the LED matrix scan engine: stimulus, flow control and verdict.
module rgb_led_matrix_pwm_scanner_test;
  import rlmps_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;
  logic               out_valid;
  logic               out_ready;
  logic [ROW_W-1:0]   scan_row;
  logic [LEVEL_W-1:0] scan_level;
  logic [MASK_W-1:0]  green_bits;
  logic [MASK_W-1:0]  red_bits;
  logic [MASK_W-1:0]  blue_bits;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  blue_out;

  int fail_count;
  int pending;
  int checked;
  int sent_per_cmd [4];
  int hold_requests;
  int holds_done;
  bit calm;

  rgb_led_matrix_pwm_scanner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .row_i        (row),
    .column_i     (column),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .scan_row_o   (scan_row),
    .scan_level_o (scan_level),
    .green_bits_o (green_bits),
    .red_bits_o   (red_bits),
    .blue_bits_o  (blue_bits),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out)
  );

  rgb_led_matrix_pwm_scanner_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_i        (cmd),
    .row_i        (row),
    .column_i     (column),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .scan_row_i   (scan_row),
    .scan_level_i (scan_level),
    .green_bits_i (green_bits),
    .red_bits_i   (red_bits),
    .blue_bits_i  (blue_bits),
    .red_out_i    (red_out),
    .green_out_i  (green_out),
    .blue_out_i   (blue_out),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("rgb_led_matrix_pwm_scanner_test: errors");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones; none while calm.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Favor values around the gray levels so the compares sit near their edge.
  function automatic logic [CHAN_W-1:0] pick_intensity();
    int p;
    p = $urandom_range(99);
    if (p < 40) return CHAN_W'($urandom_range(17, 0));
    if (p < 50) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd15;
        default: return 8'd16;
      endcase
    end
    return CHAN_W'($urandom_range(255));
  endfunction

  // Receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    int n;
    out_ready = 1'b0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_requests > holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic send_item(cmd_e op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                           logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                           logic [CHAN_W-1:0] blue);
    int gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    cmd      <= op;
    row      <= r;
    column   <= c;
    red_in   <= red;
    green_in <= green;
    blue_in  <= blue;
    do @(posedge clk_i); while (!in_ready);
    sent_per_cmd[op]++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_random_item();
    int p;
    cmd_e op;
    p = $urandom_range(99);
    if (p < 35)      op = CMD_SET;
    else if (p < 45) op = CMD_CLEAR;
    else if (p < 70) op = CMD_READ;
    else             op = CMD_SCAN;
    send_item(op, ROW_W'($urandom_range(7)), COL_W'($urandom_range(7)),
              pick_intensity(), pick_intensity(), pick_intensity());
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int waited;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    cmd           = '0;
    row           = '0;
    column        = '0;
    red_in        = '0;
    green_in      = '0;
    blue_in       = '0;
    calm          = 1'b0;
    hold_requests = 0;
    sent_per_cmd  = '{default: 0};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: cleared frame, extremes, readback, a full frame of scans, clear
    send_item(CMD_READ, 0, 0, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_SCAN, 7, 7, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_SET, 7, 7, 8'd255, 8'd255, 8'd255);
    send_item(CMD_SET, 0, 0, 8'd1, 8'd0, 8'd255);
    send_item(CMD_SET, 0, 7, 8'h80, 8'h0F, 8'h10);
    send_item(CMD_SET, 1, 3, 8'd2, 8'd16, 8'd15);
    send_item(CMD_READ, 0, 0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_READ, 0, 7, 8'd0, 8'd0, 8'd0);
    send_item(CMD_READ, 7, 7, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 8; i++) send_item(CMD_SCAN, 0, 0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_SCAN, 0, 0, 8'd0, 8'd0, 8'd0);
    send_item(CMD_CLEAR, 7, 7, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ, 7, 7, 8'd0, 8'd0, 8'd0);
    send_item(CMD_SET, 3, 5, 8'hAA, 8'h55, 8'h01);
    send_item(CMD_READ, 3, 5, 8'd0, 8'd0, 8'd0);
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold while items keep coming back to back
      if (i == 250) begin
        hold_requests++;
        calm = 1'b1;
      end
      if (i == 270 || i == 560) calm = 1'b0;
      if (i == 450) drain();
      if (i == 500) calm = 1'b1;
      send_random_item();
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);

    $display("covered %0d set, %0d clear, %0d read and %0d scan items",
             sent_per_cmd[CMD_SET], sent_per_cmd[CMD_CLEAR],
             sent_per_cmd[CMD_READ], sent_per_cmd[CMD_SCAN]);
    $display("compared %0d results, %0d long output holds, %0d left waiting",
             checked, holds_done, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_led_matrix_pwm_scanner_test: clean");
    end else begin
      $display("rgb_led_matrix_pwm_scanner_test: errors");
    end
    $finish;
  end

endmodule
